@@ rtl/nfcrfp_pkg.sv @@
// shared types and constants for the nfc response frame parser
// no dependencies

package nfcrfp_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned OUT_W    = 16;

	typedef logic [BYTE_W-1:0]   byte_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_OK      = 3'd0;
	localparam status_t ST_LCS     = 3'd1;
	localparam status_t ST_ZEROLEN = 3'd2;
	localparam status_t ST_IDENT   = 3'd3;
	localparam status_t ST_DCS     = 3'd4;

	localparam byte_t BYTE_ZERO    = 8'h00;
	localparam byte_t BYTE_START   = 8'hFF;
	localparam byte_t IDENT_IN     = 8'hD5;
	localparam byte_t MAX_PAYLOAD_RST = 8'd64;

	typedef struct packed {
		logic    is_status;
		byte_t   data_byte;
		status_t status_code;
	} result_t;

endpackage

@@ rtl/nfc_response_frame_parser_top.sv @@
// nfc response frame parser: one received byte per transfer in, payload bytes and
// a closing status out; the result is registered on the accepting input transfer
// throughput one byte per cycle while the output register does not stall, set by the phase state machine
// output register stalls the input only while a result waits and tready is low
// arst_n clears phase, counters, output valid and sets max_payload to 64
// depends on nfcrfp_pkg

module nfc_response_frame_parser_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  nfcrfp_pkg::byte_t   s_axis_tdata,  // [7:0] rx_byte
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [nfcrfp_pkg::OUT_W-1:0] m_axis_tdata,  // [7:0] data_byte, [10:8] status_code, rest zero
	output logic                m_axis_tuser,  // [0] is_status
	input  logic                cfg_we,
	input  nfcrfp_pkg::byte_t   cfg_wdata      // max_payload
);
	import nfcrfp_pkg::*;

	typedef enum logic [2:0] {
		PH_ZERO1 = 3'd0,
		PH_ZERO2 = 3'd1,
		PH_FF    = 3'd2,
		PH_LEN   = 3'd3,
		PH_LCS   = 3'd4,
		PH_BODY  = 3'd5,
		PH_DCS   = 3'd6,
		PH_POST  = 3'd7
	} phase_t;

	phase_t  phase_q, phase_d;
	byte_t   max_payload_q;
	byte_t   frame_length_q, frame_length_d;
	byte_t   tail_q, tail_d;
	byte_t   sum_q, sum_d;
	logic    ident_bad_q, ident_bad_d;
	logic    out_valid_q;
	result_t out_q;
	logic    res_valid;
	result_t res;
	logic    accept;
	byte_t   b;
	byte_t   pos_m1;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign b             = s_axis_tdata;
	assign pos_m1        = tail_q - 8'd1;

	always_comb begin
		phase_d        = phase_q;
		frame_length_d = frame_length_q;
		tail_d         = tail_q;
		sum_d          = sum_q;
		ident_bad_d    = ident_bad_q;
		res_valid      = 1'b0;
		res            = '{is_status: 1'b0, data_byte: BYTE_ZERO, status_code: ST_OK};
		case (phase_q)
			PH_ZERO1: begin
				phase_d = (b == BYTE_ZERO) ? PH_ZERO2 : PH_ZERO1;
			end
			PH_ZERO2: begin
				phase_d = (b == BYTE_ZERO) ? PH_FF : PH_ZERO1;
			end
			PH_FF: begin
				if (b == BYTE_START) begin
					phase_d = PH_LEN;
				end else if (b == BYTE_ZERO) begin
					phase_d = PH_FF;
				end else begin
					phase_d = PH_ZERO1;
				end
			end
			PH_LEN: begin
				frame_length_d = b;
				phase_d        = PH_LCS;
			end
			PH_LCS: begin
				if (byte_t'(frame_length_q + b) != BYTE_ZERO) begin
					phase_d         = PH_ZERO1;
					res_valid       = 1'b1;
					res.is_status   = 1'b1;
					res.status_code = ST_LCS;
				end else if (frame_length_q == BYTE_ZERO) begin
					phase_d         = PH_ZERO1;
					res_valid       = 1'b1;
					res.is_status   = 1'b1;
					res.status_code = ST_ZEROLEN;
				end else begin
					sum_d       = BYTE_ZERO;
					tail_d      = BYTE_ZERO;
					ident_bad_d = 1'b0;
					phase_d     = PH_BODY;
				end
			end
			PH_BODY: begin
				sum_d = sum_q + b;
				if (tail_q == BYTE_ZERO) begin
					ident_bad_d = (b != IDENT_IN);
				end else if (pos_m1 < max_payload_q) begin
					res_valid     = 1'b1;
					res.data_byte = b;
				end
				tail_d = tail_q + 8'd1;
				if (tail_d >= frame_length_q) begin
					phase_d = PH_DCS;
				end
			end
			PH_DCS: begin
				sum_d   = sum_q + b;
				phase_d = PH_POST;
			end
			PH_POST: begin
				phase_d       = PH_ZERO1;
				res_valid     = 1'b1;
				res.is_status = 1'b1;
				if (ident_bad_q) begin
					res.status_code = ST_IDENT;
				end else if (sum_q != BYTE_ZERO) begin
					res.status_code = ST_DCS;
				end else begin
					res.status_code = ST_OK;
				end
			end
			default: begin
				phase_d = PH_ZERO1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_ZERO1;
			frame_length_q <= BYTE_ZERO;
			tail_q         <= BYTE_ZERO;
			sum_q          <= BYTE_ZERO;
			ident_bad_q    <= 1'b0;
			max_payload_q  <= MAX_PAYLOAD_RST;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_payload_q <= cfg_wdata;
			end
			if (accept) begin
				phase_q        <= phase_d;
				frame_length_q <= frame_length_d;
				tail_q         <= tail_d;
				sum_q          <= sum_d;
				ident_bad_q    <= ident_bad_d;
				out_valid_q    <= res_valid;
			end else if (m_axis_tready) begin
				out_valid_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.is_status;
	assign m_axis_tdata  = {5'd0, out_q.status_code, out_q.data_byte};

`ifndef SYNTHESIS
	a_status_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[7:0] == BYTE_ZERO))
		else $error("status result carries a data byte");

	a_payload_ok_code: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[10:8] == ST_OK))
		else $error("payload result carries a status code");

	a_post_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_POST) |=>
		(phase_q == PH_ZERO1 && m_axis_tvalid && m_axis_tuser))
		else $error("postamble did not close the frame");

	a_payload_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res_valid && !res.is_status) |->
		(phase_q == PH_BODY && tail_q != BYTE_ZERO))
		else $error("payload byte outside the frame body");
`endif

endmodule

@@ verif/tb_top.sv @@
// self-checking testbench for nfc_response_frame_parser_top: random and directed byte streams
// are checked against a cycle-free frame parser model kept in this file
// depends on nfcrfp_pkg and the rtl of nfc_response_frame_parser_top

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import nfcrfp_pkg::*;

	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned PHASE_BYTES   = 275;
	localparam int unsigned WHOLE_FRAME   = 1000;

	typedef enum logic [2:0] {
		HUNT_ZERO1,
		HUNT_ZERO2,
		HUNT_FF,
		TAKE_LEN,
		TAKE_LCS,
		TAKE_BODY,
		TAKE_DCS,
		TAKE_POST
	} frame_phase_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	byte_t       s_axis_tdata = '0;    // [7:0] rx_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;         // [7:0] data_byte, [10:8] status_code
	logic        m_axis_tuser;         // [0] is_status
	logic        cfg_we = 1'b0;
	byte_t       cfg_wdata = '0;

	byte_t       rx_bytes[$];
	result_t     expected_results[$];
	int unsigned queued_bytes = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned fail_cnt = 0;
	int unsigned stall_cycles = 0;

	frame_phase_e rx_phase = HUNT_ZERO1;
	byte_t        frame_len = '0;
	logic [8:0]   body_count = '0;
	byte_t        body_sum = '0;
	logic         ident_bad = 1'b0;
	byte_t        payload_limit = MAX_PAYLOAD_RST;

	nfc_response_frame_parser_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic parse_rx_byte(input byte_t b);
		result_t r;
		r = '0;
		r.is_status = 1'b1;
		case (rx_phase)
			HUNT_ZERO1: begin
				if (b == BYTE_ZERO)
					rx_phase = HUNT_ZERO2;
			end
			HUNT_ZERO2: begin
				rx_phase = (b == BYTE_ZERO) ? HUNT_FF : HUNT_ZERO1;
			end
			HUNT_FF: begin
				if (b == BYTE_START)
					rx_phase = TAKE_LEN;
				else if (b != BYTE_ZERO)
					rx_phase = HUNT_ZERO1;
			end
			TAKE_LEN: begin
				frame_len = b;
				rx_phase = TAKE_LCS;
			end
			TAKE_LCS: begin
				if (byte_t'(frame_len + b) != BYTE_ZERO) begin
					r.status_code = ST_LCS;
					expected_results.push_back(r);
					rx_phase = HUNT_ZERO1;
				end else if (frame_len == BYTE_ZERO) begin
					r.status_code = ST_ZEROLEN;
					expected_results.push_back(r);
					rx_phase = HUNT_ZERO1;
				end else begin
					body_sum = '0;
					body_count = '0;
					ident_bad = 1'b0;
					rx_phase = TAKE_BODY;
				end
			end
			TAKE_BODY: begin
				body_sum = byte_t'(body_sum + b);
				if (body_count == 9'd0) begin
					ident_bad = (b != IDENT_IN);
				end else if (body_count - 9'd1 < {1'b0, payload_limit}) begin
					r.is_status = 1'b0;
					r.data_byte = b;
					r.status_code = ST_OK;
					expected_results.push_back(r);
				end
				body_count = body_count + 9'd1;
				if (body_count >= {1'b0, frame_len})
					rx_phase = TAKE_DCS;
			end
			TAKE_DCS: begin
				body_sum = byte_t'(body_sum + b);
				rx_phase = TAKE_POST;
			end
			default: begin
				if (ident_bad)
					r.status_code = ST_IDENT;
				else if (body_sum != BYTE_ZERO)
					r.status_code = ST_DCS;
				else
					r.status_code = ST_OK;
				expected_results.push_back(r);
				rx_phase = HUNT_ZERO1;
			end
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				parse_rx_byte(s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (rx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= rx_bytes.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n) begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected: tuser %0b tdata %h",
						m_axis_tuser, m_axis_tdata);
					fail_cnt++;
				end else begin
					want = expected_results.pop_front();
					if (m_axis_tuser !== want.is_status) begin
						$error("is_status mismatch: expected %0d, actual %0d",
							want.is_status, m_axis_tuser);
						fail_cnt++;
					end
					if (m_axis_tdata[7:0] !== want.data_byte) begin
						$error("data_byte mismatch: expected %h, actual %h",
							want.data_byte, m_axis_tdata[7:0]);
						fail_cnt++;
					end
					if (m_axis_tdata[10:8] !== want.status_code) begin
						$error("status_code mismatch: expected %0d, actual %0d",
							want.status_code, m_axis_tdata[10:8]);
						fail_cnt++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("nfc_response_frame_parser_top test failed");
		$finish;
	end

	// lead zeros, start, len, lcs; body, dcs, postamble if lcs ok, len > 0; keep truncates
	task automatic queue_frame(input int unsigned len, input byte_t ident, input bit lcs_ok,
		input bit dcs_ok, input int unsigned lead_zeros, input int unsigned keep);
		byte_t frame[$];
		byte_t sum;
		byte_t b;
		frame = {};
		repeat (lead_zeros) frame.push_back(BYTE_ZERO);
		frame.push_back(BYTE_START);
		frame.push_back(byte_t'(len));
		frame.push_back(lcs_ok ? byte_t'(-len) : byte_t'(-len + $urandom_range(1, 255)));
		if (lcs_ok && len != 0) begin
			sum = ident;
			frame.push_back(ident);
			for (int i = 1; i < len; i++) begin
				b = byte_t'($urandom);
				sum = byte_t'(sum + b);
				frame.push_back(b);
			end
			frame.push_back(dcs_ok ? byte_t'(-sum) : byte_t'(-sum + $urandom_range(1, 255)));
			frame.push_back(byte_t'($urandom));
		end
		foreach (frame[i]) begin
			if (i < keep) begin
				rx_bytes.push_back(frame[i]);
				queued_bytes++;
			end
		end
	endtask

	task automatic queue_random();
		int unsigned pick;
		int unsigned len;
		byte_t ident;
		pick = $urandom_range(99);
		if ($urandom_range(19) == 0)
			len = $urandom_range(1) ? 255 : $urandom_range(100, 254);
		else
			len = $urandom_range(1, 20);
		ident = ($urandom_range(9) == 0) ? byte_t'($urandom) : IDENT_IN;
		if (pick < 72) begin
			queue_frame(len, ident, $urandom_range(19) != 0, $urandom_range(9) != 0,
				$urandom_range(2, 4), WHOLE_FRAME);
		end else if (pick < 76) begin
			queue_frame(0, ident, 1'b1, 1'b1, 2, WHOLE_FRAME);
		end else if (pick < 88) begin
			queue_frame(len, ident, 1'b1, 1'b1, 2, $urandom_range(1, len + 5));
		end else begin
			repeat ($urandom_range(1, 8)) begin
				case ($urandom_range(3))
					0: rx_bytes.push_back(BYTE_ZERO);
					1: rx_bytes.push_back(BYTE_START);
					2: rx_bytes.push_back(IDENT_IN);
					default: rx_bytes.push_back(byte_t'($urandom));
				endcase
				queued_bytes++;
			end
		end
	endtask

	task automatic wait_quiet();
		do
			@(negedge clk);
		while (rx_bytes.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_max_payload(input byte_t value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		payload_limit = value;
		@(negedge clk);
	endtask

	initial begin
		byte_t limit_plan[6];
		limit_plan[0] = MAX_PAYLOAD_RST;
		limit_plan[1] = 8'd0;
		limit_plan[2] = 8'd255;
		limit_plan[3] = 8'd1;
		limit_plan[4] = byte_t'($urandom_range(2, 254));
		limit_plan[5] = MAX_PAYLOAD_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int p = 0; p < 6; p++) begin
			if (p != 0) begin
				wait_quiet();
				write_max_payload(limit_plan[p]);
			end
			send_idle_pct = (p < 2) ? 22 : (p < 4) ? 83 : 0;
			recv_idle_pct = (p < 2) ? 83 : (p < 4) ? 22 : 0;
			queued_bytes = 0;
			if (p == 0) begin
				// shortest good frame, hunt restarts, bad lcs, zero length,
				// extra zeros with bad identifier and bad dcs together
				queue_frame(1, IDENT_IN, 1'b1, 1'b1, 2, WHOLE_FRAME);
				rx_bytes.push_back(BYTE_ZERO);
				rx_bytes.push_back(8'h5A);
				rx_bytes.push_back(BYTE_ZERO);
				rx_bytes.push_back(BYTE_ZERO);
				rx_bytes.push_back(8'h7E);
				queue_frame(5, IDENT_IN, 1'b0, 1'b1, 2, WHOLE_FRAME);
				queue_frame(0, IDENT_IN, 1'b1, 1'b1, 2, WHOLE_FRAME);
				queue_frame(2, 8'h12, 1'b1, 1'b0, 3, WHOLE_FRAME);
			end
			while (queued_bytes < PHASE_BYTES)
				queue_random();
		end
		wait_quiet();
		if (fail_cnt == 0 && expected_results.size() == 0)
			$display("nfc_response_frame_parser_top test passed");
		else
			$display("nfc_response_frame_parser_top test failed");
		$finish;
	end

endmodule

@@ nfc_response_frame_parser_top.f @@
rtl/nfcrfp_pkg.sv
rtl/nfc_response_frame_parser_top.sv
verif/tb_top.sv
